@@ design/fipid_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fipid_pkg
// Shared types and constants of the five-channel incremental PID controller.
// ----------------------------------------------------------------------------
package fipid_pkg;

	localparam int CHANNELS = 5;

	localparam logic signed [31:0] DRIVE_MAX = 32'sd65534;
	localparam logic signed [31:0] DRIVE_MIN = 32'sh8000_0000;

	localparam logic [7:0]  KP_RESET    = 8'd5;
	localparam logic [7:0]  KD_RESET    = 8'd10;
	localparam logic [7:0]  KI_RESET    = 8'd0;
	localparam logic [15:0] SCALE_RESET = 16'd21043;

	typedef enum logic [1:0] {
		REG_KP    = 2'd0,
		REG_KD    = 2'd1,
		REG_KI    = 2'd2,
		REG_SCALE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  kp;
		logic [7:0]  kd;
		logic [7:0]  ki;
		logic [15:0] scale;
	} gains_t;

	typedef struct packed {
		logic s1_en;
		logic s2_en;
		logic s3_en;
		logic s4_en;
	} lane_ctl_t;

endpackage

@@ design/fipid_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fipid_lane
// One PID channel: speed scaling, error terms, gain products and clamped
// drive accumulation over four stages, with per-channel state.
// ----------------------------------------------------------------------------
module fipid_lane (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire fipid_pkg::gains_t       gains,
	input  wire fipid_pkg::lane_ctl_t    ctl,
	input  wire logic signed [15:0]      target,
	input  wire logic signed [15:0]      delta,
	output logic signed [31:0]           drive
);
	import fipid_pkg::*;

	logic signed [32:0] prod_c;
	logic signed [32:0] prod_s1;
	logic signed [15:0] target_s1;

	logic signed [32:0] rounded_c;
	logic signed [15:0] speed_c;
	logic signed [15:0] err_c;
	logic signed [15:0] diff_c;
	logic signed [15:0] sum_c;
	logic signed [15:0] err_s2;
	logic signed [15:0] diff_s2;
	logic signed [15:0] sum_s2;
	logic signed [15:0] last_error_q;
	logic signed [15:0] error_sum_q;

	logic signed [24:0] pterm_c;
	logic signed [24:0] dterm_c;
	logic signed [24:0] iterm_c;
	logic signed [24:0] pterm_s3;
	logic signed [24:0] dterm_s3;
	logic signed [24:0] iterm_s3;

	logic signed [33:0] acc_c;
	logic signed [31:0] acc_sat_c;
	logic signed [31:0] drive_q;

	assign prod_c = 33'(delta) * 33'($signed({1'b0, gains.scale}));

	always_ff @(posedge clk) begin
		if (ctl.s1_en) begin
			prod_s1   <= prod_c;
			target_s1 <= target;
		end
	end

	assign rounded_c = prod_s1 + (prod_s1[32] ? 33'sd255 : 33'sd0);
	assign speed_c   = rounded_c[23:8];
	assign err_c     = target_s1 - speed_c;
	assign diff_c    = err_c - last_error_q;
	assign sum_c     = error_sum_q + err_c;

	always_ff @(posedge clk) begin
		if (ctl.s2_en) begin
			err_s2  <= err_c;
			diff_s2 <= diff_c;
			sum_s2  <= sum_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
			error_sum_q  <= '0;
		end else if (ctl.s2_en) begin
			last_error_q <= err_c;
			error_sum_q  <= sum_c;
		end
	end

	assign pterm_c = 25'($signed({1'b0, gains.kp})) * 25'(err_s2);
	assign dterm_c = 25'($signed({1'b0, gains.kd})) * 25'(diff_s2);
	assign iterm_c = 25'($signed({1'b0, gains.ki})) * 25'(sum_s2);

	always_ff @(posedge clk) begin
		if (ctl.s3_en) begin
			pterm_s3 <= pterm_c;
			dterm_s3 <= dterm_c;
			iterm_s3 <= iterm_c;
		end
	end

	assign acc_c = 34'(drive_q) + 34'(pterm_s3) + 34'(dterm_s3) + 34'(iterm_s3);

	always_comb begin
		if (acc_c > 34'(DRIVE_MAX)) begin
			acc_sat_c = DRIVE_MAX;
		end else if (acc_c < 34'(DRIVE_MIN)) begin
			acc_sat_c = DRIVE_MIN;
		end else begin
			acc_sat_c = acc_c[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= '0;
		end else if (ctl.s4_en) begin
			drive_q <= acc_sat_c;
		end
	end

	assign drive = drive_q;

endmodule
`default_nettype wire

@@ design/fipid_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fipid_merge
// Output stage: gathers the drive values of all lanes into one result item
// and holds it until the receiver takes it.
// ----------------------------------------------------------------------------
module fipid_merge (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                res_pending,
	input  wire logic signed [31:0]  lane_drive [fipid_pkg::CHANNELS],
	output logic                     move,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [31:0]       drive_out [fipid_pkg::CHANNELS]
);
	import fipid_pkg::*;

	logic               out_valid_q;
	logic signed [31:0] drive_q [CHANNELS];

	assign move = res_pending && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			for (int k = 0; k < CHANNELS; k++) begin
				drive_q[k] <= lane_drive[k];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign drive_out = drive_q;

endmodule
`default_nettype wire

@@ design/five_channel_incremental_pid.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// five_channel_incremental_pid
// Incremental PID speed controller for four wheels and a kicker.
//
// Usage:
//   Each input item carries five setpoints and five encoder deltas; each
//   result item carries the five clamped drive accumulators after that tick.
//   Input and output channels use valid/stall; an item moves when valid is
//   high and stall is low. The configuration channel (cfg_valid/cfg_ready,
//   cfg_index, cfg_data) writes the gains and the count-to-rpm scale, is always
//   ready; the user must write it only while no item is in flight (unchecked).
//   Five lanes work in parallel through four stages (scale product, error
//   terms, gain products, accumulate and clamp); one item is in flight at a
//   time, so in_stall stays high from accept until the result enters the
//   output register.
//   An accepted item passes the four lane stages and then the output register;
//   the next item is accepted once that result has entered the output register.
//   A stalled receiver holds the result in the output register; the next item
//   may be accepted and run, and waits in the lanes until the register frees.
//   Reset clears all channel state and loads the default gains.
// ----------------------------------------------------------------------------
module five_channel_incremental_pid (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic signed [15:0]  target_wheel_a,
	input  wire logic signed [15:0]  target_wheel_b,
	input  wire logic signed [15:0]  target_wheel_c,
	input  wire logic signed [15:0]  target_wheel_d,
	input  wire logic signed [15:0]  target_kicker,
	input  wire logic signed [15:0]  delta_wheel_a,
	input  wire logic signed [15:0]  delta_wheel_b,
	input  wire logic signed [15:0]  delta_wheel_c,
	input  wire logic signed [15:0]  delta_wheel_d,
	input  wire logic signed [15:0]  delta_kicker,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [31:0]       drive_wheel_a,
	output logic signed [31:0]       drive_wheel_b,
	output logic signed [31:0]       drive_wheel_c,
	output logic signed [31:0]       drive_wheel_d,
	output logic signed [31:0]       drive_kicker,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data
);
	import fipid_pkg::*;

	gains_t             gains_q;
	lane_ctl_t          ctl;
	logic               in_acc;
	logic               busy_q;
	logic               v_s1_q;
	logic               v_s2_q;
	logic               v_s3_q;
	logic               res_pend_q;
	logic               move;
	logic signed [15:0] target_arr [CHANNELS];
	logic signed [15:0] delta_arr [CHANNELS];
	logic signed [31:0] lane_drive [CHANNELS];
	logic signed [31:0] drive_arr [CHANNELS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.kp    <= KP_RESET;
			gains_q.kd    <= KD_RESET;
			gains_q.ki    <= KI_RESET;
			gains_q.scale <= SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_KP:    gains_q.kp    <= cfg_data[7:0];
				REG_KD:    gains_q.kd    <= cfg_data[7:0];
				REG_KI:    gains_q.ki    <= cfg_data[7:0];
				REG_SCALE: gains_q.scale <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			v_s1_q     <= 1'b0;
			v_s2_q     <= 1'b0;
			v_s3_q     <= 1'b0;
			res_pend_q <= 1'b0;
		end else begin
			v_s1_q <= in_acc;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (v_s3_q) begin
				res_pend_q <= 1'b1;
			end else if (move) begin
				res_pend_q <= 1'b0;
			end
		end
	end

	always_comb begin
		ctl.s1_en = in_acc;
		ctl.s2_en = v_s1_q;
		ctl.s3_en = v_s2_q;
		ctl.s4_en = v_s3_q;
	end

	assign target_arr[0] = target_wheel_a;
	assign target_arr[1] = target_wheel_b;
	assign target_arr[2] = target_wheel_c;
	assign target_arr[3] = target_wheel_d;
	assign target_arr[4] = target_kicker;
	assign delta_arr[0]  = delta_wheel_a;
	assign delta_arr[1]  = delta_wheel_b;
	assign delta_arr[2]  = delta_wheel_c;
	assign delta_arr[3]  = delta_wheel_d;
	assign delta_arr[4]  = delta_kicker;

	for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
		fipid_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.gains  (gains_q),
			.ctl    (ctl),
			.target (target_arr[k]),
			.delta  (delta_arr[k]),
			.drive  (lane_drive[k])
		);
	end

	fipid_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_pending (res_pend_q),
		.lane_drive  (lane_drive),
		.move        (move),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drive_out   (drive_arr)
	);

	assign drive_wheel_a = drive_arr[0];
	assign drive_wheel_b = drive_arr[1];
	assign drive_wheel_c = drive_arr[2];
	assign drive_wheel_d = drive_arr[3];
	assign drive_kicker  = drive_arr[4];

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (v_s1_q && busy_q))
		else $error("accepted item did not enter the lanes");

	a_one_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1_q, v_s2_q, v_s3_q, res_pend_q}))
		else $error("more than one item in flight");

	a_busy_cover: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1_q || v_s2_q || v_s3_q || res_pend_q) |-> busy_q)
		else $error("input open while an item is in flight");

	a_move_frees: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> (!busy_q && !res_pend_q && out_valid))
		else $error("result hand-off left the block busy");

endmodule
`default_nettype wire
